FILE: rtl/assert_macros.svh
// Assertion macros shared by the profiler event statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PES_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is held.
`define PES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/pes_pkg.sv
// Types and constants shared by the profiler event statistics modules.
package pes_pkg;

    typedef enum logic [1:0] {
        OP_SWITCH = 2'd0,
        OP_IRQ    = 2'd1,
        OP_SLEEP  = 2'd2,
        OP_OTHER  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_LEN     = 2'd1,
        STATUS_KIND    = 2'd2,
        STATUS_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_SWITCH = 2'd0,
        CMD_IRQ    = 2'd1,
        CMD_SLEEP  = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_kind_t;

    // Required payload lengths per event kind.
    localparam logic [3:0] LEN_SWITCH = 4'd2;
    localparam logic [3:0] LEN_IRQ    = 4'd2;
    localparam logic [3:0] LEN_SLEEP  = 4'd3;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        cmd_kind_t   kind;
        status_t     status;
        logic [7:0]  drop;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic updating;
    } back_stat_t;

endpackage

FILE: rtl/profiler_event_statistics_top.sv
// Flow: the back end answers a sleep, an error, an ignored event or a switch that finds
// the table full straight from its idle state; a context switch or interrupt has its
// counter RAM read first and the new count written back and reported in the update
// state, and no new command is taken from the queue until that update is done.
// Reset: synchronous, active low; afterwards a clearing sweep over every counter RAM
// address zeroes the counter RAMs, and s_ready stays low until it ends.
`include "assert_macros.svh"

module profiler_event_statistics_top #(
    parameter int TABLE_ENTRIES = 20,
    parameter int IRQ_LINES     = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [3:0]  s_payload_words,
    input  logic [7:0]  s_dropped_events,
    input  logic [31:0] s_first_word,
    input  logic [31:0] s_second_word,
    input  logic [31:0] s_third_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_slot,
    output logic [31:0] m_event_count,
    output logic [31:0] m_dropped_total
);
    import pes_pkg::*;

    // The front end classifies each transaction as it arrives and pushes a command into a
    // short queue, so that a new transaction can be taken while the back end is still
    // busy with a counter update or waiting for the result register to drain.
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_head_valid;
    cmd_t       q_push_data;
    cmd_t       q_head_data;
    back_stat_t bk_stat;

    pes_front #(.IRQ_LINES(IRQ_LINES)) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_payload_words  (s_payload_words),
        .s_dropped_events (s_dropped_events),
        .s_first_word     (s_first_word),
        .s_second_word    (s_second_word),
        .s_third_word     (s_third_word),
        .enable           (!bk_stat.clearing),
        .q_full           (q_full),
        .push             (q_push),
        .push_data        (q_push_data)
    );

    pes_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // The back end owns every store: the thread id table, the switch and interrupt
    // counter RAMs, the sleep record and the dropped-event total. It handles one command
    // at a time and holds the result in a register until the downstream side takes it.
    pes_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IRQ_LINES     (IRQ_LINES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (q_head_valid),
        .head_data       (q_head_data),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_event_count   (m_event_count),
        .m_dropped_total (m_dropped_total),
        .stat            (bk_stat)
    );

    // No transaction is taken while the counter RAMs are being cleared.
    `PES_ASSERT_IMPLIES(a_no_accept_while_clearing, aclk, aresetn, s_ready, !bk_stat.clearing)
    // An update step only starts once the result register has been freed.
    `PES_ASSERT_IMPLIES(a_update_has_free_output, aclk, aresetn, bk_stat.updating, !m_valid)
    // Every update step presents its result on the next cycle.
    `PES_ASSERT_NEXT(a_update_gives_result, aclk, aresetn, bk_stat.updating, m_valid)
    // Error and ignored results carry neither a slot nor a count.
    `PES_ASSERT_IMPLIES(a_error_fields_zero, aclk, aresetn, m_valid && (m_status != STATUS_OK), (m_slot == 5'd0) && (m_event_count == 32'd0))

endmodule

FILE: rtl/pes_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pes_front.sv
// Front end: accepts trace events, checks length and kind, and queues a command.
module pes_front #(
    parameter int IRQ_LINES = 255
) (
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_op,
    input  logic [3:0]   s_payload_words,
    input  logic [7:0]   s_dropped_events,
    input  logic [31:0]  s_first_word,
    input  logic [31:0]  s_second_word,
    input  logic [31:0]  s_third_word,
    input  logic         enable,
    input  logic         q_full,
    output logic         push,
    output pes_pkg::cmd_t push_data
);
    import pes_pkg::*;

    cmd_t cmd;

    always_comb begin
        cmd        = '0;
        cmd.drop   = s_dropped_events;
        cmd.w0     = s_first_word;
        cmd.w1     = s_second_word;
        cmd.w2     = s_third_word;
        cmd.kind   = CMD_REPORT;
        cmd.status = STATUS_OK;
        unique case (op_t'(s_op))
            OP_SWITCH: begin
                if (s_payload_words != LEN_SWITCH) begin
                    cmd.status = STATUS_LEN;
                end else begin
                    cmd.kind = CMD_SWITCH;
                end
            end
            OP_IRQ: begin
                if (s_payload_words != LEN_IRQ) begin
                    cmd.status = STATUS_LEN;
                end else if (s_second_word < 32'(IRQ_LINES)) begin
                    cmd.kind = CMD_IRQ;
                end else begin
                    cmd.status = STATUS_IGNORED;
                end
            end
            OP_SLEEP: begin
                if (s_payload_words != LEN_SLEEP) begin
                    cmd.status = STATUS_LEN;
                end else begin
                    cmd.kind = CMD_SLEEP;
                end
            end
            default: begin
                cmd.status = STATUS_KIND;
            end
        endcase
    end

    assign s_ready   = enable && !q_full;
    assign push      = s_valid && s_ready;
    assign push_data = cmd;

endmodule

FILE: rtl/pes_queue.sv
// Short command queue between the front end and the back end.
module pes_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pes_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pes_pkg::cmd_t head_data
);
    import pes_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/pes_back.sv
// Back end: thread table lookup, counter updates, dropped total and the result register.
module pes_back #(
    parameter int TABLE_ENTRIES = 20,
    parameter int IRQ_LINES     = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  pes_pkg::cmd_t       head_data,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [4:0]          m_slot,
    output logic [31:0]         m_event_count,
    output logic [31:0]         m_dropped_total,
    output pes_pkg::back_stat_t stat
);
    import pes_pkg::*;

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LINE_W = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
    localparam int CLR_N  = (IRQ_LINES > TABLE_ENTRIES) ? IRQ_LINES : TABLE_ENTRIES;
    localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [31:0] clr_wide;

    logic [31:0] ids_reg [TABLE_ENTRIES];
    logic [31:0] ids_next [TABLE_ENTRIES];

    logic              pend_switch_reg, pend_switch_next;
    logic              pend_new_reg, pend_new_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [LINE_W-1:0] pend_line_reg, pend_line_next;
    logic [31:0]       pend_id_reg, pend_id_next;
    logic [31:0]       pend_stamp_reg, pend_stamp_next;

    logic [31:0] dropped_reg, dropped_next;
    logic [31:0] sleep_cause_reg, sleep_cause_next;
    logic [31:0] sleep_start_reg, sleep_start_next;
    logic [31:0] sleep_duration_reg, sleep_duration_next;

    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg, out_status_next;
    logic [4:0]  out_slot_reg, out_slot_next;
    logic [31:0] out_count_reg, out_count_next;
    logic [31:0] out_total_reg, out_total_next;

    logic              hit_any, free_any;
    logic [SLOT_W-1:0] hit_idx, free_idx;
    logic              accept;
    logic [31:0]       drop_sum;
    logic [31:0]       slot_wide;
    logic [31:0]       new_count;

    logic              sw_we;
    logic [SLOT_W-1:0] sw_waddr;
    logic [31:0]       sw_wdata;
    logic [31:0]       ts_wdata;
    logic [SLOT_W-1:0] sw_raddr;
    logic [31:0]       sw_rdata;
    logic              irq_we;
    logic [LINE_W-1:0] irq_waddr;
    logic [31:0]       irq_wdata;
    logic [LINE_W-1:0] irq_raddr;
    logic [31:0]       irq_rdata;

    // Parallel tag compare: first matching slot and first free slot.
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (ids_reg[i] == head_data.w1) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (ids_reg[i] == '0) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign accept    = (state_reg == ST_IDLE) && head_valid && (!out_valid_reg || m_ready);
    assign pop       = accept;
    assign drop_sum  = dropped_reg + 32'(head_data.drop);
    assign sw_raddr  = hit_any ? hit_idx : free_idx;
    assign irq_raddr = head_data.w1[LINE_W-1:0];
    assign slot_wide = 32'(pend_slot_reg);
    assign clr_wide  = 32'(clr_reg);
    assign new_count = pend_switch_reg ? (pend_new_reg ? 32'd1 : sw_rdata + 32'd1)
                                       : irq_rdata + 32'd1;

    always_comb begin
        state_next          = state_reg;
        clr_next            = clr_reg;
        ids_next            = ids_reg;
        pend_switch_next    = pend_switch_reg;
        pend_new_next       = pend_new_reg;
        pend_slot_next      = pend_slot_reg;
        pend_line_next      = pend_line_reg;
        pend_id_next        = pend_id_reg;
        pend_stamp_next     = pend_stamp_reg;
        dropped_next        = dropped_reg;
        sleep_cause_next    = sleep_cause_reg;
        sleep_start_next    = sleep_start_reg;
        sleep_duration_next = sleep_duration_reg;
        out_valid_next      = out_valid_reg;
        out_status_next     = out_status_reg;
        out_slot_next       = out_slot_reg;
        out_count_next      = out_count_reg;
        out_total_next      = out_total_reg;
        sw_we               = 1'b0;
        sw_waddr            = pend_slot_reg;
        sw_wdata            = new_count;
        ts_wdata            = pend_stamp_reg;
        irq_we              = 1'b0;
        irq_waddr           = pend_line_reg;
        irq_wdata           = new_count;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                sw_we     = (clr_wide < 32'(TABLE_ENTRIES));
                sw_waddr  = clr_reg[SLOT_W-1:0];
                sw_wdata  = '0;
                ts_wdata  = '0;
                irq_we    = (clr_wide < 32'(IRQ_LINES));
                irq_waddr = clr_reg[LINE_W-1:0];
                irq_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_wide == 32'(CLR_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    dropped_next    = drop_sum;
                    out_total_next  = drop_sum;
                    out_status_next = STATUS_OK;
                    out_slot_next   = '0;
                    out_count_next  = '0;
                    pend_id_next    = head_data.w1;
                    pend_stamp_next = head_data.w0;
                    pend_line_next  = head_data.w1[LINE_W-1:0];
                    pend_slot_next  = sw_raddr;
                    pend_new_next   = !hit_any;
                    unique case (head_data.kind)
                        CMD_SWITCH: begin
                            if (hit_any || free_any) begin
                                pend_switch_next = 1'b1;
                                state_next       = ST_UPDATE;
                            end else begin
                                out_status_next = STATUS_IGNORED;
                                out_valid_next  = 1'b1;
                            end
                        end
                        CMD_IRQ: begin
                            pend_switch_next = 1'b0;
                            state_next       = ST_UPDATE;
                        end
                        CMD_SLEEP: begin
                            sleep_cause_next    = head_data.w2;
                            sleep_start_next    = head_data.w0;
                            sleep_duration_next = head_data.w1;
                            out_valid_next      = 1'b1;
                        end
                        default: begin
                            out_status_next = head_data.status;
                            out_valid_next  = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                // Counter read data is available now; write back and report.
                if (pend_switch_reg) begin
                    sw_we         = 1'b1;
                    out_slot_next = slot_wide[4:0];
                    if (pend_new_reg) begin
                        ids_next[pend_slot_reg] = pend_id_reg;
                    end
                end else begin
                    irq_we = 1'b1;
                end
                out_count_next = new_count;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            dropped_reg   <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                ids_reg[i] <= '0;
            end
            sleep_cause_reg    <= '0;
            sleep_start_reg    <= '0;
            sleep_duration_reg <= '0;
        end else begin
            state_reg          <= state_next;
            clr_reg            <= clr_next;
            out_valid_reg      <= out_valid_next;
            dropped_reg        <= dropped_next;
            ids_reg            <= ids_next;
            sleep_cause_reg    <= sleep_cause_next;
            sleep_start_reg    <= sleep_start_next;
            sleep_duration_reg <= sleep_duration_next;
        end
        pend_switch_reg <= pend_switch_next;
        pend_new_reg    <= pend_new_next;
        pend_slot_reg   <= pend_slot_next;
        pend_line_reg   <= pend_line_next;
        pend_id_reg     <= pend_id_next;
        pend_stamp_reg  <= pend_stamp_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_count_reg   <= out_count_next;
        out_total_reg   <= out_total_next;
    end

    pes_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_switch_ram (
        .aclk  (aclk),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .raddr (sw_raddr),
        .rdata (sw_rdata)
    );

    // Last switch timestamp per thread; kept for inspection, not reported.
    pes_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_stamp_ram (
        .aclk  (aclk),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (ts_wdata),
        .raddr (sw_raddr),
        .rdata ()
    );

    pes_ram #(.WIDTH(32), .DEPTH(IRQ_LINES)) u_irq_ram (
        .aclk  (aclk),
        .we    (irq_we),
        .waddr (irq_waddr),
        .wdata (irq_wdata),
        .raddr (irq_raddr),
        .rdata (irq_rdata)
    );

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_slot          = out_slot_reg;
    assign m_event_count   = out_count_reg;
    assign m_dropped_total = out_total_reg;
    assign stat.clearing   = (state_reg == ST_CLEAR);
    assign stat.updating   = (state_reg == ST_UPDATE);

endmodule

FILE: bench/pes_event_checker.sv
// Scoreboard for the profiler event statistics block: prediction and result comparison.
module pes_event_checker #(
    parameter int TABLE_ENTRIES = 20,
    parameter int IRQ_LINES     = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [3:0]  s_payload_words,
    input  logic [7:0]  s_dropped_events,
    input  logic [31:0] s_first_word,
    input  logic [31:0] s_second_word,
    input  logic [31:0] s_third_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [4:0]  m_slot,
    input  logic [31:0] m_event_count,
    input  logic [31:0] m_dropped_total,
    output int          mismatch_count,
    output int          outcomes_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import pes_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [4:0]  slot;
        logic [31:0] count;
        logic [31:0] dropped;
    } event_outcome_t;

    // Shadow copy of the block's tables and latches.
    logic [31:0] thread_tag   [TABLE_ENTRIES];
    logic [31:0] thread_stamp [TABLE_ENTRIES];
    logic [31:0] thread_hits  [TABLE_ENTRIES];
    logic [31:0] line_hits    [IRQ_LINES];
    logic [31:0] nap_cause, nap_start, nap_length;
    logic [31:0] lost_sum;

    event_outcome_t awaited_outcomes[$];

    initial begin
        mismatch_count   = 0;
        outcomes_awaited = 0;
    end

    function automatic event_outcome_t tally_event(op_t kind, logic [3:0] len,
                                                   logic [7:0] drop, logic [31:0] w0,
                                                   logic [31:0] w1, logic [31:0] w2);
        event_outcome_t r;
        int             hit;
        bit             fresh;
        r      = '{status: STATUS_OK, slot: '0, count: '0, dropped: '0};
        hit    = -1;
        fresh  = 1'b0;
        lost_sum = lost_sum + 32'(drop);
        case (kind)
            OP_SWITCH: begin
                if (len != LEN_SWITCH) begin
                    r.status = STATUS_LEN;
                end else begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (hit < 0 && thread_tag[i] == w1) hit = i;
                    // A new thread claims the first free slot; its count starts afresh.
                    if (hit < 0) begin
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                            if (hit < 0 && thread_tag[i] == '0) hit = i;
                        fresh = 1'b1;
                    end
                    if (hit < 0) begin
                        r.status = STATUS_IGNORED;
                    end else begin
                        thread_tag[hit]   = w1;
                        thread_stamp[hit] = w0;
                        thread_hits[hit]  = fresh ? 32'd1 : thread_hits[hit] + 32'd1;
                        r.slot  = 5'(hit);
                        r.count = thread_hits[hit];
                    end
                end
            end
            OP_IRQ: begin
                if (len != LEN_IRQ) begin
                    r.status = STATUS_LEN;
                end else if (w1 < 32'(IRQ_LINES)) begin
                    line_hits[w1] = line_hits[w1] + 32'd1;
                    r.count = line_hits[w1];
                end else begin
                    r.status = STATUS_IGNORED;
                end
            end
            OP_SLEEP: begin
                if (len != LEN_SLEEP) begin
                    r.status = STATUS_LEN;
                end else begin
                    nap_cause  = w2;
                    nap_start  = w0;
                    nap_length = w1;
                end
            end
            default: r.status = STATUS_KIND;
        endcase
        r.dropped = lost_sum;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        event_outcome_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                thread_tag[i]   = '0;
                thread_stamp[i] = '0;
                thread_hits[i]  = '0;
            end
            for (int i = 0; i < IRQ_LINES; i++) line_hits[i] = '0;
            nap_cause  = '0;
            nap_start  = '0;
            nap_length = '0;
            lost_sum   = '0;
            awaited_outcomes.delete();
        end else begin
            if (s_valid && s_ready)
                awaited_outcomes.push_back(tally_event(op_t'(s_op), s_payload_words,
                                                       s_dropped_events, s_first_word,
                                                       s_second_word, s_third_word));
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("unexpected result (dropped total)", m_dropped_total, '0);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_slot !== want.slot)
                        report_mismatch("slot", 32'(m_slot), 32'(want.slot));
                    if (m_event_count !== want.count)
                        report_mismatch("event count", m_event_count, want.count);
                    if (m_dropped_total !== want.dropped)
                        report_mismatch("dropped total", m_dropped_total, want.dropped);
                end
            end
        end
        outcomes_awaited = awaited_outcomes.size();
    end

endmodule

FILE: bench/testbench.sv
// Top of the profiler event statistics bench: clock, reset, stimulus, receiver and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pes_pkg::*;

    localparam int TABLE_ENTRIES  = 20;
    localparam int IRQ_LINES      = 255;
    // Thread ids drawn by the random part; more than the table holds, so it fills up.
    localparam int ID_POOL        = 26;
    localparam int RANDOM_EVENTS  = 830;
    // The longest quiet stretch of a correct run is the clearing sweep after reset or
    // the receiver's long hold-off; this limit leaves ample room for either.
    localparam int WATCHDOG_LIMIT = 4000;
    // Transaction count after which the receiver holds off for a long stretch.
    localparam int HOLD_OFF_AFTER = 300;
    localparam int HOLD_OFF_SPAN  = 400;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op             = '0;
    logic [3:0]  s_payload_words  = '0;
    logic [7:0]  s_dropped_events = '0;
    logic [31:0] s_first_word     = '0;
    logic [31:0] s_second_word    = '0;
    logic [31:0] s_third_word     = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [1:0]  m_status;
    logic [4:0]  m_slot;
    logic [31:0] m_event_count;
    logic [31:0] m_dropped_total;

    int mismatch_count;
    int outcomes_awaited;
    int events_sent  = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;

    logic [31:0] thread_pool [ID_POOL];

    profiler_event_statistics_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IRQ_LINES     (IRQ_LINES)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_payload_words  (s_payload_words),
        .s_dropped_events (s_dropped_events),
        .s_first_word     (s_first_word),
        .s_second_word    (s_second_word),
        .s_third_word     (s_third_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot           (m_slot),
        .m_event_count    (m_event_count),
        .m_dropped_total  (m_dropped_total)
    );

    // The checker sits beside the block, watching both channels; it predicts every
    // result and hands back the number of mismatches and of results still outstanding.
    pes_event_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IRQ_LINES     (IRQ_LINES)
    ) i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_payload_words  (s_payload_words),
        .s_dropped_events (s_dropped_events),
        .s_first_word     (s_first_word),
        .s_second_word    (s_second_word),
        .s_third_word     (s_third_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot           (m_slot),
        .m_event_count    (m_event_count),
        .m_dropped_total  (m_dropped_total),
        .mismatch_count   (mismatch_count),
        .outcomes_awaited (outcomes_awaited)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a run in which no transaction moves on either channel for too long
    // has hung, so it is ended and failed.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("profiler_event_statistics_top test failed");
                $finish;
            end
        end
    end

    // Offers one event, called just after a falling edge, and returns at a falling edge.
    // The payload is held steady until the block takes the transaction. The sender works
    // in bursts: when one burst is spent, valid is dropped for a random gap.
    task automatic offer_event(op_t kind, logic [3:0] len, logic [7:0] drop,
                               logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
        s_op             <= kind;
        s_payload_words  <= len;
        s_dropped_events <= drop;
        s_first_word     <= w0;
        s_second_word    <= w1;
        s_third_word     <= w2;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(0, 48);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver: it changes its behaviour from one random span to the next, between always ready,
    // random stalls, a fixed one-in-five stall pattern and mostly stalled. Once, after
    // a few hundred transactions, it holds off for a long stretch so that the block
    // fills up and has to push back on its input while the sender keeps offering.
    initial begin : receiver
        int  mode;
        int  span;
        int  tick;
        bit  held_off;
        held_off = 1'b0;
        tick     = 0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (tick % 5) != 0;
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            if (!held_off && events_sent >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_OFF_SPAN) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        op_t         kind;
        logic [3:0]  len;
        logic [3:0]  needed;
        logic [7:0]  drop;
        logic [31:0] w0, w1, w2;
        int          roll;
        int          pick;

        // The pool holds the two extreme ids and random ones; id zero stands for a
        // free slot, which the block treats as a thread of its own.
        thread_pool[0] = 32'h0000_0000;
        thread_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < ID_POOL; i++) thread_pool[i] = $urandom;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed events. Sleep latches with all-ones and all-zero words.
        offer_event(OP_SLEEP, LEN_SLEEP, 8'hFF, '1, '1, '1);
        offer_event(OP_SLEEP, LEN_SLEEP, 8'h00, '0, '0, '0);
        // Thread id zero matches the first free slot and only bumps its count;
        // the slot stays free, so the next new thread claims it with a count of one.
        offer_event(OP_SWITCH, LEN_SWITCH, 8'h01, '1, 32'h0, '0);
        offer_event(OP_SWITCH, LEN_SWITCH, 8'h02, 32'h10, 32'h0, '1);
        offer_event(OP_SWITCH, LEN_SWITCH, 8'h03, 32'h20, '1, '0);
        offer_event(OP_SWITCH, LEN_SWITCH, 8'h04, 32'h30, 32'h0, '0);
        offer_event(OP_SWITCH, LEN_SWITCH, 8'h05, '0, '1, '0);
        offer_event(OP_SWITCH, LEN_SWITCH, 8'h06, 32'h40, 32'h1234_5678, '0);
        // Interrupt lines at both ends of the range, and just beyond it.
        offer_event(OP_IRQ, LEN_IRQ, 8'h07, '1, 32'd0, '0);
        offer_event(OP_IRQ, LEN_IRQ, 8'h08, '0, 32'(IRQ_LINES - 1), '0);
        offer_event(OP_IRQ, LEN_IRQ, 8'h09, '0, 32'(IRQ_LINES), '0);
        offer_event(OP_IRQ, LEN_IRQ, 8'h0A, '0, '1, '0);
        offer_event(OP_IRQ, LEN_IRQ, 8'h0B, '0, 32'd0, '0);
        // Wrong payload lengths for every known kind, for switches at both extremes.
        offer_event(OP_SWITCH, 4'd0, 8'h0C, '0, 32'h55, '0);
        offer_event(OP_SWITCH, 4'd15, 8'h0D, '0, 32'h55, '0);
        offer_event(OP_IRQ, 4'd3, 8'h0E, '0, 32'd3, '0);
        offer_event(OP_SLEEP, 4'd2, 8'h0F, '1, '1, '1);
        offer_event(OP_SLEEP, 4'd15, 8'h10, '1, '1, '1);
        // Unknown kind, whatever its length.
        offer_event(OP_OTHER, 4'd2, 8'h11, '0, '0, '0);
        offer_event(OP_OTHER, 4'd0, 8'hFF, '0, '0, '0);
        offer_event(OP_OTHER, 4'd15, 8'hFF, '1, '1, '1);

        // Random events, mostly well formed. Switches mostly draw from the id pool, which is
        // larger than the table, so the table fills and later new threads are ignored.
        // Interrupts mostly hit a few low lines so that their counts climb.
        repeat (RANDOM_EVENTS) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            drop = 8'($urandom_range(0, 255));
            w0   = $urandom;
            w1   = $urandom;
            w2   = $urandom;
            if (roll < 35) begin
                kind = OP_SWITCH;
                len  = LEN_SWITCH;
                if (pick != 0) w1 = thread_pool[$urandom_range(0, ID_POOL - 1)];
            end else if (roll < 65) begin
                kind = OP_IRQ;
                len  = LEN_IRQ;
                if (pick < 7)
                    w1 = $urandom_range(0, 15);
                else if (pick < 9)
                    w1 = $urandom_range(0, IRQ_LINES - 1);
                else if ($urandom_range(0, 1) == 1)
                    w1 = $urandom_range(IRQ_LINES, IRQ_LINES + 8);
            end else if (roll < 80) begin
                kind = OP_SLEEP;
                len  = LEN_SLEEP;
            end else if (roll < 90) begin
                kind   = op_t'($urandom_range(0, 2));
                needed = (kind == OP_SLEEP) ? LEN_SLEEP :
                         (kind == OP_IRQ)   ? LEN_IRQ : LEN_SWITCH;
                do len = 4'($urandom_range(0, 15)); while (len == needed);
            end else begin
                kind = OP_OTHER;
                len  = 4'($urandom_range(0, 15));
            end
            offer_event(kind, len, drop, w0, w1, w2);
        end

        s_valid <= 1'b0;
        // Let every outstanding result drain, then allow a short spell in which any
        // stray extra result would still be caught by the checker.
        while (outcomes_awaited != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && outcomes_awaited == 0) begin
            $display("profiler_event_statistics_top test passed");
        end else begin
            $display("profiler_event_statistics_top test failed");
        end
        $finish;
    end

endmodule
